// ===== src/jinv_pkg.sv =====
// Shared types and constants for the Jacobian inverse pipeline.
`default_nettype none

package jinv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Nine matrix entries, row major
    localparam int N_ENT = 9;

    // Dimension register codes
    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;

    // Control that rides along with each beat
    typedef struct packed {
        logic valid;
        logic dim2;
    } t_ctl;

endpackage

`default_nettype wire

// ===== src/jinv_cofactor.sv =====
// Cofactor stages: 18 two-term products, then the 3x3 cofactor differences.
`default_nettype none

module jinv_cofactor #(
    parameter int W = jinv_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jinv_pkg::t_ctl     i_ctl,
    input  logic [W-1:0]       i_jac [jinv_pkg::N_ENT],
    output jinv_pkg::t_ctl     o_ctl,
    output logic [2*W:0]       o_cof [jinv_pkg::N_ENT],
    output logic [W-1:0]       o_jac [jinv_pkg::N_ENT]
);
    import jinv_pkg::*;

    localparam int CW = 2*W + 1;

    t_ctl                 r_ctl1;
    t_ctl                 r_ctl2;
    logic signed [2*W-1:0] r_pa [N_ENT];
    logic signed [2*W-1:0] r_pb [N_ENT];
    logic [W-1:0]         r_jac1 [N_ENT];
    logic [W-1:0]         r_jac2 [N_ENT];
    logic [CW-1:0]        r_cof [N_ENT];

    // Valid and mode travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_jac1 <= i_jac;
        r_jac2 <= r_jac1;
    end

    // cof[i][c] = a[c+1][i+1]*a[c+2][i+2] - a[c+1][i+2]*a[c+2][i+1], indices mod 3
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            localparam int R1 = (gc + 1) % 3;
            localparam int R2 = (gc + 2) % 3;
            localparam int C1 = (gi + 1) % 3;
            localparam int C2 = (gi + 2) % 3;
            localparam int E  = gi*3 + gc;

            always_ff @(posedge i_clk) begin
                r_pa[E]  <= $signed(i_jac[R1*3+C1]) * $signed(i_jac[R2*3+C2]);
                r_pb[E]  <= $signed(i_jac[R1*3+C2]) * $signed(i_jac[R2*3+C1]);
                r_cof[E] <= CW'(r_pa[E]) - CW'(r_pb[E]);
            end
        end
    end

    assign o_ctl = r_ctl2;
    assign o_cof = r_cof;
    assign o_jac = r_jac2;

endmodule

`default_nettype wire

// ===== src/jinv_det.sv =====
// Determinant stages: mode select, split products, sum, zero fix, magnitudes.
`default_nettype none

module jinv_det #(
    parameter int W = jinv_pkg::DATA_WIDTH_DEF,
    parameter int F = jinv_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jinv_pkg::t_ctl              i_ctl,
    input  logic [2*W:0]                i_cof [jinv_pkg::N_ENT],
    input  logic [W-1:0]                i_jac [jinv_pkg::N_ENT],
    output jinv_pkg::t_ctl              o_ctl,
    output logic [3*W+1:0]              o_den,
    output logic [2*W+2*F:0]            o_num [jinv_pkg::N_ENT],
    output logic [jinv_pkg::N_ENT-1:0]  o_neg
);
    import jinv_pkg::*;

    localparam int CW = 2*W + 1;
    localparam int DW = 3*W + 2;
    localparam int NW = CW + 2*F;

    t_ctl                 r_ctl3;
    t_ctl                 r_ctl4;
    t_ctl                 r_ctl5;
    t_ctl                 r_ctl6;
    logic signed [2*W:0]  r_pl [3];
    logic signed [2*W:0]  r_ph [3];
    logic signed [CW-1:0] r_det2;
    logic [CW-1:0]        n_cof [N_ENT];
    logic [CW-1:0]        r_cof3 [N_ENT];
    logic [CW-1:0]        r_cof4 [N_ENT];
    logic [CW-1:0]        r_cof5 [N_ENT];
    logic signed [CW-1:0] r_det2_4;
    logic [DW-1:0]        r_sl;
    logic [DW-1:0]        r_sh;
    logic [DW-1:0]        n_det;
    logic [DW-1:0]        r_det5;
    logic [DW-1:0]        r_den;
    logic [NW-1:0]        r_num [N_ENT];
    logic [N_ENT-1:0]     r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
        end else begin
            r_ctl3 <= i_ctl;
            r_ctl4 <= r_ctl3;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
        end
    end

    // Bottom-row products, each cofactor split into low W bits and signed high part
    for (genvar gc = 0; gc < 3; gc++) begin : g_part
        always_ff @(posedge i_clk) begin
            r_pl[gc] <= $signed(i_jac[6+gc]) * $signed({1'b0, i_cof[gc*3+2][W-1:0]});
            r_ph[gc] <= $signed(i_jac[6+gc]) * $signed(i_cof[gc*3+2][CW-1:W]);
        end
    end

    // 2x2 mode uses the swapped/negated upper-left entries, zero elsewhere
    always_comb begin
        for (int e = 0; e < N_ENT; e++) begin
            n_cof[e] = i_ctl.dim2 ? '0 : i_cof[e];
        end
        if (i_ctl.dim2) begin
            n_cof[0] = CW'($signed(i_jac[4]));
            n_cof[1] = -CW'($signed(i_jac[1]));
            n_cof[3] = -CW'($signed(i_jac[3]));
            n_cof[4] = CW'($signed(i_jac[0]));
        end
    end

    // Stages 3 and 4: cofactor select, partial sums
    always_ff @(posedge i_clk) begin
        r_cof3   <= n_cof;
        r_det2   <= i_cof[8];
        r_cof4   <= r_cof3;
        r_det2_4 <= r_det2;
        r_sl     <= DW'(r_pl[0]) + DW'(r_pl[1]) + DW'(r_pl[2]);
        r_sh     <= DW'(r_ph[0]) + DW'(r_ph[1]) + DW'(r_ph[2]);
    end

    // Determinant, a zero one taken as 1.0 at its own scale
    always_comb begin
        n_det = r_ctl4.dim2 ? DW'(r_det2_4) : (r_sh << W) + r_sl;
        if (n_det == '0) begin
            n_det = r_ctl4.dim2 ? (DW'(1) << (2*F)) : (DW'(1) << (3*F));
        end
    end

    // Stages 5 and 6: determinant, then magnitudes and quotient signs
    // (cofactor magnitude is taken at its own width before widening)
    always_ff @(posedge i_clk) begin
        r_det5 <= n_det;
        r_cof5 <= r_cof4;
        r_den  <= r_det5[DW-1] ? -r_det5 : r_det5;
        for (int e = 0; e < N_ENT; e++) begin
            r_num[e] <= NW'(CW'(r_cof5[e][CW-1] ? -r_cof5[e] : r_cof5[e])) << (2*F);
            r_neg[e] <= r_cof5[e][CW-1] ^ r_det5[DW-1];
        end
    end

    assign o_ctl = r_ctl6;
    assign o_den = r_den;
    assign o_num = r_num;
    assign o_neg = r_neg;

endmodule

`default_nettype wire

// ===== src/jinv_divider.sv =====
// Restoring divider, one quotient bit per stage, nine lanes sharing one divisor.
`default_nettype none

module jinv_divider #(
    parameter int W  = jinv_pkg::DATA_WIDTH_DEF,
    parameter int DW = 3*W + 2,
    parameter int NW = 2*W + 1 + 2*jinv_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jinv_pkg::t_ctl              i_ctl,
    input  logic [DW-1:0]               i_den,
    input  logic [NW-1:0]               i_num [jinv_pkg::N_ENT],
    input  logic [jinv_pkg::N_ENT-1:0]  i_neg,
    output jinv_pkg::t_ctl              o_ctl,
    output logic [W+1:0]                o_quo [jinv_pkg::N_ENT],
    output logic [jinv_pkg::N_ENT-1:0]  o_neg
);
    import jinv_pkg::*;

    // Quotient bits W+1..0; the top bit only flags overflow
    localparam int QW = W + 2;
    localparam int TW = DW + QW - 1;
    localparam int AW = (TW > NW) ? TW : NW;

    t_ctl             r_ctl [QW];
    logic [N_ENT-1:0] r_neg [QW];
    logic [QW-1:0]    r_quo [QW][N_ENT];
    logic [DW-1:0]    r_den [QW-1];
    logic [AW-1:0]    r_rem [QW-1][N_ENT];

    for (genvar gs = 0; gs < QW; gs++) begin : g_stage
        localparam int K = QW - 1 - gs;

        t_ctl             ctl_in;
        logic [DW-1:0]    den_in;
        logic [N_ENT-1:0] neg_in;
        logic [AW-1:0]    rem_in [N_ENT];
        logic [QW-1:0]    quo_in [N_ENT];
        logic [AW-1:0]    trial;
        logic [N_ENT-1:0] ge;

        if (gs == 0) begin : g_head
            always_comb begin
                ctl_in = i_ctl;
                den_in = i_den;
                neg_in = i_neg;
                for (int l = 0; l < N_ENT; l++) begin
                    rem_in[l] = AW'(i_num[l]);
                    quo_in[l] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                ctl_in = r_ctl[gs-1];
                den_in = r_den[gs-1];
                neg_in = r_neg[gs-1];
                for (int l = 0; l < N_ENT; l++) begin
                    rem_in[l] = r_rem[gs-1][l];
                    quo_in[l] = r_quo[gs-1][l];
                end
            end
        end

        // Compare against the divisor shifted to this bit
        always_comb begin
            trial = AW'(den_in) << K;
            for (int l = 0; l < N_ENT; l++) begin
                ge[l] = rem_in[l] >= trial;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[gs] <= '0;
            end else begin
                r_ctl[gs] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[gs] <= neg_in;
            for (int l = 0; l < N_ENT; l++) begin
                r_quo[gs][l] <= quo_in[l] | (ge[l] ? (QW'(1) << K) : '0);
            end
        end

        // Remainder and divisor are not needed past the last bit
        if (gs < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_den[gs] <= den_in;
                for (int l = 0; l < N_ENT; l++) begin
                    r_rem[gs][l] <= ge[l] ? rem_in[l] - trial : rem_in[l];
                end
            end
        end
    end

    assign o_ctl = r_ctl[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_neg = r_neg[QW-1];

endmodule

`default_nettype wire

// ===== src/jacobian_inverse_2d_3d.sv =====
// Top level: 2x2/3x3 Jacobian inverse pipeline with saturation and output register.
//
// Usage:
//   Input channel: start with the nine jac fields; a beat is taken at a clock
//   edge where start is high and busy is low. busy is high during reset and
//   until the first edge after it, so one matrix can be taken every cycle.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_dimension; ready is
//   always high. Value 2 selects 2x2 inversion, anything else 3x3. Write it
//   only while no matrix is in flight.
//   Result channel: o_valid is high for one cycle with the nine inverse
//   entries and o_saturated. The receiver cannot stall the block.
// Pipeline: DATA_WIDTH+9 register stages: two cofactor stages, four
//   determinant stages, DATA_WIDTH+2 divider stages (one quotient bit each)
//   and the output stage.
// Throughput: one matrix per cycle, set by the fully pipelined divider.
// Reset: synchronous, active low; clears all valid bits in flight and sets
//   the dimension to 3.
`default_nettype none

module jacobian_inverse_2d_3d #(
    parameter int DATA_WIDTH = jinv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = jinv_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_dimension,
    input  logic signed [DATA_WIDTH-1:0] i_jac_00,
    input  logic signed [DATA_WIDTH-1:0] i_jac_01,
    input  logic signed [DATA_WIDTH-1:0] i_jac_02,
    input  logic signed [DATA_WIDTH-1:0] i_jac_10,
    input  logic signed [DATA_WIDTH-1:0] i_jac_11,
    input  logic signed [DATA_WIDTH-1:0] i_jac_12,
    input  logic signed [DATA_WIDTH-1:0] i_jac_20,
    input  logic signed [DATA_WIDTH-1:0] i_jac_21,
    input  logic signed [DATA_WIDTH-1:0] i_jac_22,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_inv_00,
    output logic signed [DATA_WIDTH-1:0] o_inv_01,
    output logic signed [DATA_WIDTH-1:0] o_inv_02,
    output logic signed [DATA_WIDTH-1:0] o_inv_10,
    output logic signed [DATA_WIDTH-1:0] o_inv_11,
    output logic signed [DATA_WIDTH-1:0] o_inv_12,
    output logic signed [DATA_WIDTH-1:0] o_inv_20,
    output logic signed [DATA_WIDTH-1:0] o_inv_21,
    output logic signed [DATA_WIDTH-1:0] o_inv_22,
    output logic                         o_saturated
);
    import jinv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = 2*W + 1;
    localparam int DW  = 3*W + 2;
    localparam int NW  = CW + 2*F;
    localparam int QW  = W + 2;
    localparam int LAT = W + 9;

    localparam logic [W:0]   LIM_P = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   LIM_N = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};

    logic             r_ready;
    logic [1:0]       r_dimension;
    t_ctl             w_ctl_in;
    logic [W-1:0]     w_jac [N_ENT];
    t_ctl             w_ctl_cof;
    logic [CW-1:0]    w_cof [N_ENT];
    logic [W-1:0]     w_jac_cof [N_ENT];
    t_ctl             w_ctl_det;
    logic [DW-1:0]    w_den;
    logic [NW-1:0]    w_num [N_ENT];
    logic [N_ENT-1:0] w_neg_det;
    t_ctl             w_ctl_div;
    logic [QW-1:0]    w_quo [N_ENT];
    logic [N_ENT-1:0] w_neg_div;
    logic [N_ENT-1:0] n_over;
    logic [W-1:0]     n_inv [N_ENT];
    logic [W-1:0]     r_inv [N_ENT];
    logic             r_sat;
    logic             r_valid;

    // Handshake and dimension register
    assign busy        = ~r_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_dimension <= DIM_3D;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dimension <= i_cfg_dimension;
            end
        end
    end

    assign w_ctl_in.valid = start & ~busy;
    assign w_ctl_in.dim2  = (r_dimension == DIM_2D);

    assign w_jac[0] = i_jac_00;
    assign w_jac[1] = i_jac_01;
    assign w_jac[2] = i_jac_02;
    assign w_jac[3] = i_jac_10;
    assign w_jac[4] = i_jac_11;
    assign w_jac[5] = i_jac_12;
    assign w_jac[6] = i_jac_20;
    assign w_jac[7] = i_jac_21;
    assign w_jac[8] = i_jac_22;

    jinv_cofactor #(
        .W (W)
    ) u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_jac   (w_jac),
        .o_ctl   (w_ctl_cof),
        .o_cof   (w_cof),
        .o_jac   (w_jac_cof)
    );

    jinv_det #(
        .W (W),
        .F (F)
    ) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_cof),
        .i_cof   (w_cof),
        .i_jac   (w_jac_cof),
        .o_ctl   (w_ctl_det),
        .o_den   (w_den),
        .o_num   (w_num),
        .o_neg   (w_neg_det)
    );

    jinv_divider #(
        .W  (W),
        .DW (DW),
        .NW (NW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_det),
        .i_den   (w_den),
        .i_num   (w_num),
        .i_neg   (w_neg_det),
        .o_ctl   (w_ctl_div),
        .o_quo   (w_quo),
        .o_neg   (w_neg_div)
    );

    // Clip each magnitude to the signed range, then apply the sign
    always_comb begin
        logic [W:0] lim;
        logic [W:0] mag;
        for (int l = 0; l < N_ENT; l++) begin
            lim       = w_neg_div[l] ? LIM_N : LIM_P;
            n_over[l] = w_quo[l][QW-1] | (w_quo[l][QW-2:0] > lim);
            mag       = n_over[l] ? lim : w_quo[l][QW-2:0];
            n_inv[l]  = w_neg_div[l] ? -mag[W-1:0] : mag[W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv <= n_inv;
        r_sat <= |n_over;
    end

    assign o_valid     = r_valid;
    assign o_inv_00    = r_inv[0];
    assign o_inv_01    = r_inv[1];
    assign o_inv_02    = r_inv[2];
    assign o_inv_10    = r_inv[3];
    assign o_inv_11    = r_inv[4];
    assign o_inv_12    = r_inv[5];
    assign o_inv_20    = r_inv[6];
    assign o_inv_21    = r_inv[7];
    assign o_inv_22    = r_inv[8];
    assign o_saturated = r_sat;

    // Every accepted beat comes out a fixed time later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted beat produced no result strobe");

    // No result strobe without an accepted beat behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted beat");

    // 2x2 mode leaves the third row and column at zero
    a_zero_2d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_dimension == DIM_2D) |->
        (o_inv_02 == '0 && o_inv_12 == '0 && o_inv_20 == '0 &&
         o_inv_21 == '0 && o_inv_22 == '0))
        else $error("nonzero outer entry in 2x2 mode");

    // A saturation flag means some entry sits at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_inv_00 == MAXV || o_inv_00 == MINV || o_inv_01 == MAXV ||
         o_inv_01 == MINV || o_inv_02 == MAXV || o_inv_02 == MINV ||
         o_inv_10 == MAXV || o_inv_10 == MINV || o_inv_11 == MAXV ||
         o_inv_11 == MINV || o_inv_12 == MAXV || o_inv_12 == MINV ||
         o_inv_20 == MAXV || o_inv_20 == MINV || o_inv_21 == MAXV ||
         o_inv_21 == MINV || o_inv_22 == MAXV || o_inv_22 == MINV))
        else $error("saturated flag without a clipped entry");

endmodule

`default_nettype wire

// ===== dv/tb_jacobian_inverse_2d_3d.sv =====
// Testbench for the 2x2/3x3 Jacobian inverse pipeline: directed and random matrices.
`default_nettype none

module tb_jacobian_inverse_2d_3d;
    timeunit 1ns;
    timeprecision 1ps;

    import jinv_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_LAT = DW + 8;

    typedef logic [N_ENT-1:0][DW-1:0] mat_t;
    typedef struct packed {
        mat_t m;
        logic sat;
    } inv_res_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_dimension;
    logic signed [DW-1:0] jac [N_ENT];
    logic          o_valid;
    logic signed [DW-1:0] inv [N_ENT];
    logic          o_saturated;

    jacobian_inverse_2d_3d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_dimension(i_cfg_dimension),
        .i_jac_00(jac[0]), .i_jac_01(jac[1]), .i_jac_02(jac[2]),
        .i_jac_10(jac[3]), .i_jac_11(jac[4]), .i_jac_12(jac[5]),
        .i_jac_20(jac[6]), .i_jac_21(jac[7]), .i_jac_22(jac[8]),
        .o_valid(o_valid),
        .o_inv_00(inv[0]), .o_inv_01(inv[1]), .o_inv_02(inv[2]),
        .o_inv_10(inv[3]), .o_inv_11(inv[4]), .o_inv_12(inv[5]),
        .o_inv_20(inv[6]), .o_inv_21(inv[7]), .o_inv_22(inv[8]),
        .o_saturated(o_saturated)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [1:0] cur_dim;
    inv_res_t   pending_inv[$];
    int         n_sent, n_checked, n_errors, n_sat, n_sing;

    // Exact adjugate / determinant, truncating divide, saturate to DW bits
    function automatic inv_res_t predict_inverse(mat_t j, logic [1:0] dim);
        logic signed [191:0] a [3][3];
        logic signed [191:0] cof [3][3];
        logic signed [191:0] det, q;
        logic signed [191:0] hi, lo;
        inv_res_t r;
        int n;
        hi = (192'sd1 <<< (DW - 1)) - 192'sd1;
        lo = -(192'sd1 <<< (DW - 1));
        r = '0;
        for (int k = 0; k < 9; k++) a[k / 3][k % 3] = $signed(j[k]);
        if (dim == DIM_2D) begin
            det = a[0][0] * a[1][1] - a[1][0] * a[0][1];
            if (det == 0) det = 192'sd1 <<< (2 * FB);
            cof[0][0] = a[1][1];
            cof[0][1] = -a[0][1];
            cof[1][0] = -a[1][0];
            cof[1][1] = a[0][0];
            n = 2;
        end else begin
            for (int i = 0; i < 3; i++)
                for (int c = 0; c < 3; c++)
                    cof[i][c] = a[(c+1)%3][(i+1)%3] * a[(c+2)%3][(i+2)%3]
                              - a[(c+1)%3][(i+2)%3] * a[(c+2)%3][(i+1)%3];
            det = 0;
            for (int c = 0; c < 3; c++) det = det + a[2][c] * cof[c][2];
            if (det == 0) det = 192'sd1 <<< (3 * FB);
            n = 3;
        end
        for (int i = 0; i < n; i++)
            for (int c = 0; c < n; c++) begin
                q = (cof[i][c] <<< (2 * FB)) / det;
                if (q > hi) begin
                    q = hi;
                    r.sat = 1'b1;
                end else if (q < lo) begin
                    q = lo;
                    r.sat = 1'b1;
                end
                r.m[i*3+c] = q[DW-1:0];
            end
        return r;
    endfunction

    // Result checker: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        inv_res_t want, got;
        if (i_rst_n && o_valid) begin
            for (int k = 0; k < 9; k++) got.m[k] = inv[k];
            got.sat = o_saturated;
            if (pending_inv.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: unexpected result beat");
            end else begin
                want = pending_inv.pop_front();
                n_checked++;
                if (got.sat) n_sat++;
                for (int k = 0; k < 9; k++)
                    if (got.m[k] !== want.m[k]) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("ERROR: result %0d inv_%0d%0d exp %h got %h",
                                     n_checked, k / 3, k % 3, want.m[k], got.m[k]);
                    end
                if (got.sat !== want.sat) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d saturated exp %b got %b",
                                 n_checked, want.sat, got.sat);
                end
            end
        end
    end

    // One matrix beat, after a random gap
    task automatic send_matrix(mat_t m);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        for (int k = 0; k < 9; k++) jac[k] <= m[k];
        do @(posedge i_clk); while (busy);
        pending_inv.push_back(predict_inverse(m, cur_dim));
        n_sent++;
    endtask

    // Stop sending and let the pipe empty
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_inv.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_dimension(logic [1:0] dim);
        drain_pipe();
        i_cfg_valid     <= 1'b1;
        i_cfg_dimension <= dim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_dim = dim;
    endtask

    function automatic logic [DW-1:0] rand_modest();
        int v;
        v = $urandom_range(0, 1 << 19);
        return DW'(v - (1 << 18));
    endfunction

    function automatic logic [DW-1:0] rand_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    // Well-conditioned, wild, singular or extreme matrices
    function automatic mat_t rand_matrix();
        mat_t m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) begin
            if (kind < 5) m[k] = rand_modest();
            else if (kind < 7) m[k] = $urandom;
            else if (kind == 7) m[k] = rand_extreme();
            else m[k] = ($urandom_range(0, 1)) ? rand_modest() : $urandom;
        end
        // diagonal bias keeps most matrices invertible with sane results
        if (kind < 4)
            for (int d = 0; d < 3; d++) m[d*4] = m[d*4] + 32'h0004_0000;
        if (kind == 8) begin
            // repeated row: singular in both modes
            for (int c = 0; c < 3; c++) m[3+c] = m[c];
            n_sing++;
        end
        if (kind == 9) begin
            for (int c = 0; c < 3; c++) m[6+c] = m[c] + m[3+c];
            n_sing++;
        end
        return m;
    endfunction

    task automatic test_directed();
        mat_t m;
        write_dimension(DIM_3D);
        m = '0;
        m[0] = 32'h0001_0000; m[4] = 32'h0001_0000; m[8] = 32'h0001_0000;
        send_matrix(m);                                   // identity
        send_matrix('0);                                  // zero determinant
        send_matrix({9{32'h7FFF_FFFF}});
        send_matrix({9{32'h8000_0000}});
        m = '0;
        m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = 32'h8000_0000;
        send_matrix(m);
        m = '0;
        m[0] = 32'h0000_0001; m[4] = 32'h0000_0001; m[8] = 32'h0000_0001;
        send_matrix(m);                                   // tiny det, overflow
        m = '0;
        m[0] = 32'h7FFF_FFFF; m[4] = 32'h7FFF_FFFF; m[8] = 32'h7FFF_FFFF;
        send_matrix(m);
        m = '0;
        m[2] = 32'h0002_0000; m[4] = 32'hFFFF_0000; m[6] = 32'h0000_8000;
        send_matrix(m);                                   // permutation, signs
        write_dimension(DIM_2D);
        m = {9{32'hDEAD_BEEF}};
        m[0] = 32'h0001_0000; m[1] = 0; m[3] = 0; m[4] = 32'h0001_0000;
        send_matrix(m);                                   // unused entries ignored
        send_matrix('0);
        send_matrix({9{32'h8000_0000}});
        send_matrix({9{32'h7FFF_FFFF}});
        m = '0;
        m[0] = 32'h8000_0000; m[4] = 32'h7FFF_FFFF;
        send_matrix(m);
        m = '0;
        m[0] = 32'h0000_0001; m[4] = 32'h0000_0001;
        send_matrix(m);
        write_dimension(2'd0);
        send_matrix({9{32'h0001_0000}});
        m = '0;
        m[0] = 32'h0002_0000; m[4] = 32'h0002_0000; m[8] = 32'h0002_0000;
        send_matrix(m);
        write_dimension(2'd1);
        send_matrix(m);
        send_matrix('0);
    endtask

    task automatic test_random(logic [1:0] dim, int count);
        write_dimension(dim);
        for (int i = 0; i < count; i++) send_matrix(rand_matrix());
    endtask

    // Beats at random gaps, some back to back, with a full drain in the middle of the stream
    task automatic test_pressure(int count);
        write_dimension(DIM_3D);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_pipe();
            send_matrix(rand_matrix());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_dimension <= DIM_3D;
        for (int k = 0; k < 9; k++) jac[k] <= '0;
        cur_dim = DIM_3D;
        n_sent = 0; n_checked = 0; n_errors = 0; n_sat = 0; n_sing = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_random(DIM_3D, 20);     // 3x3 dimension written right after reset
        test_directed();
        test_random(DIM_3D, 600);
        test_random(DIM_2D, 450);
        test_random(2'd0, 120);
        test_random(2'd1, 120);
        test_pressure(220);
        drain_pipe();

        $display("Ran %0d matrices in all four dimension settings, %0d checked,", n_sent,
                 n_checked);
        $display("%0d with saturation, %0d built singular; %0d mismatches", n_sat, n_sing,
                 n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("ERROR: timeout with %0d results pending", pending_inv.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/jinv_pkg.sv
src/jinv_cofactor.sv
src/jinv_det.sv
src/jinv_divider.sv
src/jacobian_inverse_2d_3d.sv
dv/tb_jacobian_inverse_2d_3d.sv
